FILE: rtl/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// shared types and codes for the sorted value table
// ----------------------------------------------------------------------------
package svt_pkg;

	localparam int VALUE_W  = 32;
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LIST   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_REMOVED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_LISTED    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [VALUE_W-1:0]  value;
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

endpackage

FILE: rtl/svt_cell.sv
// ----------------------------------------------------------------------------
// svt_cell
// one slot of the sorted chain: compares against the broadcast value and
// takes its own, a neighbor's, the head's or the new value
// ----------------------------------------------------------------------------
module svt_cell
	import svt_pkg::*;
(
	input  logic                       clk,
	input  cell_cmd_t                  cmd,
	input  logic                       occupied,
	input  logic                       is_tail,
	input  logic                       prev_ge,
	input  logic signed [VALUE_W-1:0]  left_val,
	input  logic signed [VALUE_W-1:0]  right_val,
	input  logic signed [VALUE_W-1:0]  head_val,
	output logic signed [VALUE_W-1:0]  val,
	output logic                       lt,
	output logic                       ge,
	output logic                       eq
);

	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] val_next;

	assign val = val_q;
	assign lt  = occupied && (val_q < cmd.value);
	assign ge  = occupied && !lt;
	assign eq  = occupied && (val_q == cmd.value);

	always_comb begin
		val_next = val_q;
		case (cmd.op)
			CELL_INSERT: begin
				// cells past the insert point move right by one
				if (prev_ge) begin
					val_next = left_val;
				end else if (!lt) begin
					val_next = cmd.value;
				end
			end
			CELL_REMOVE: begin
				if (ge) begin
					val_next = right_val;
				end
			end
			CELL_ROTATE: begin
				// occupied part of the chain turns left, head wraps to the tail
				val_next = is_tail ? head_val : right_val;
			end
			default: begin
				val_next = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_next;
	end

endmodule

FILE: rtl/svt_pos_enc.sv
// ----------------------------------------------------------------------------
// svt_pos_enc
// turns the thermometer of cells below the value into its sorted index
// ----------------------------------------------------------------------------
module svt_pos_enc #(
	parameter int N     = 16,
	parameter int IDX_W = 4
) (
	input  logic [N-1:0]     lt_vec,
	output logic [IDX_W-1:0] pos
);

	logic [N-1:0] edge_hot;

	always_comb begin
		pos = '0;
		for (int i = 0; i < N; i++) begin
			if (i == 0) begin
				edge_hot[i] = !lt_vec[i];
			end else begin
				edge_hot[i] = lt_vec[i-1] && !lt_vec[i];
			end
			if (edge_hot[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

endmodule

FILE: rtl/sorted_value_table_top.sv
// insert and remove: result registered the cycle after it is taken
// list of n entries: one listed item per cycle while the output is free
// one insert or remove per cycle while the output is free; list takes one chain rotation per item
// reset clears the count, the control state and the output valid; cell contents are not reset
// ----------------------------------------------------------------------------
// sorted_value_table_top
// sorted table of signed values held in a chain of shifting cells
// ----------------------------------------------------------------------------
module sorted_value_table_top
	import svt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode[1:0], value[33:2], zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // status[2:0], entry_value[34:3],
	                                          // position[38:35], entry_count[43:39], zero pad
	output logic                   m_tlast
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_next;
	logic [CNT_W-1:0] count_q, count_next;
	logic [IDX_W-1:0] k_q, k_next;

	logic              m_tvalid_q;
	status_t           status_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   pos_q;
	logic [COUNT_W-1:0] cnt_q;
	logic              last_q;

	logic              emit;
	status_t           e_status;
	logic signed [VALUE_W-1:0] e_value;
	logic [IDX_W-1:0]  e_pos;
	logic [CNT_W-1:0]  e_cnt;
	logic              e_last;

	logic [IDX_W+POS_W-1:0]   pos_ext;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	opcode_t           in_op;
	logic signed [VALUE_W-1:0] in_value;
	logic              out_free;
	logic              accept;
	logic              full;
	logic              found;
	logic [CNT_W-1:0]  k_plus1;

	cell_cmd_t         cmd;
	logic signed [VALUE_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0] lt_vec, ge_vec, eq_vec;
	logic [IDX_W-1:0]  hit_pos;

	assign in_op    = opcode_t'(s_tdata[OPCODE_W-1:0]);
	assign in_value = s_tdata[OPCODE_W +: VALUE_W];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign found    = |eq_vec;
	assign k_plus1  = CNT_W'(k_q) + CNT_W'(1);

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_v, right_v;
		logic prev_ge;
		if (i == 0) begin : g_head
			assign left_v  = cmd.value;
			assign prev_ge = 1'b0;
		end else begin : g_mid
			assign left_v  = cell_val[i-1];
			assign prev_ge = ge_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_v = cell_val[i];
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end

		svt_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (count_q > CNT_W'(i)),
			.is_tail  (count_q == CNT_W'(i + 1)),
			.prev_ge  (prev_ge),
			.left_val (left_v),
			.right_val(right_v),
			.head_val (cell_val[0]),
			.val      (cell_val[i]),
			.lt       (lt_vec[i]),
			.ge       (ge_vec[i]),
			.eq       (eq_vec[i])
		);
	end

	svt_pos_enc #(
		.N    (CAPACITY),
		.IDX_W(IDX_W)
	) u_pos_enc (
		.lt_vec(lt_vec),
		.pos   (hit_pos)
	);

	always_comb begin
		state_next = state_q;
		count_next = count_q;
		k_next     = k_q;
		cmd.op     = CELL_HOLD;
		cmd.value  = in_value;
		emit       = 1'b0;
		e_status   = ST_INSERTED;
		e_value    = in_value;
		e_pos      = '0;
		e_cnt      = count_q;
		e_last     = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_INSERT: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								cmd.op     = CELL_INSERT;
								count_next = count_q + CNT_W'(1);
								e_cnt      = count_next;
								e_pos      = hit_pos;
							end
						end
						OP_REMOVE: begin
							emit = 1'b1;
							if (found) begin
								cmd.op     = CELL_REMOVE;
								count_next = count_q - CNT_W'(1);
								e_status   = ST_REMOVED;
								e_cnt      = count_next;
								e_pos      = hit_pos;
							end else begin
								e_status = ST_NOT_FOUND;
							end
						end
						OP_LIST: begin
							if (count_q == '0) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
								e_value  = '0;
							end else begin
								state_next = S_LIST;
								k_next     = '0;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_LIST: begin
				if (out_free) begin
					emit     = 1'b1;
					cmd.op   = CELL_ROTATE;
					e_status = ST_LISTED;
					e_value  = cell_val[0];
					e_pos    = k_q;
					e_last   = (k_plus1 == count_q);
					k_next   = k_q + IDX_W'(1);
					if (e_last) begin
						state_next = S_IDLE;
					end
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	assign pos_ext = {{POS_W{1'b0}}, e_pos};
	assign cnt_ext = {{COUNT_W{1'b0}}, e_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			count_q <= count_next;
			k_q     <= k_next;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result item payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= e_status;
			value_q  <= e_value;
			pos_q    <= pos_ext[POS_W-1:0];
			cnt_q    <= cnt_ext[COUNT_W-1:0];
			last_q   <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_TDATA_W - STATUS_W - VALUE_W - POS_W - COUNT_W){1'b0}},
		cnt_q, pos_q, value_q, status_q};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count above capacity");

	a_no_take_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> !s_tready)
		else $error("input taken during list");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_op == OP_INSERT && !full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	for (genvar j = 0; j + 1 < CAPACITY; j++) begin : g_chk_order
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			state_q == S_IDLE && count_q > CNT_W'(j + 1) |-> cell_val[j] <= cell_val[j+1])
			else $error("table out of order");
	end
`endif

endmodule
